// File: sv/activity_selection_defines.svh
// Assertion macros shared by the activity selection checker.
`ifndef ACTIVITY_SELECTION_DEFINES_SVH
`define ACTIVITY_SELECTION_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define AS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define AS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/actsel_pkg.sv
// Shared types and constants for the activity selection block.
package actsel_pkg;

  localparam int unsigned ID_W         = 16;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned CNT_W        = 6;
  localparam int unsigned RESULT_LIMIT = 32;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PLACE,
    ST_SEL_START,
    ST_SEL,
    ST_FLUSH
  } state_e;

endpackage

// File: sv/actsel_store.sv
// Job store: one write port, one read port, registered read data.
module actsel_store #(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output actsel_pkg::job_t  rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  actsel_pkg::job_t  wr_data_i
);
  import actsel_pkg::*;

  job_t mem_q [DEPTH];
  job_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/activity_selection.sv
// Greedy activity selection by earliest finish time, top level.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | job_id, start_at, finish_at, final_job
//  out     | from block| out_valid_o / out_stall_i| chosen_id, chosen_count, overflowed, run_end
//
// Load: the transaction is taken, then each stored job with a later finish moves up
//   (one read-compare-write through the store port), then the job is placed.
//   A load into an empty or full store finishes when the transaction is taken.
// Selection after final_job: the store is scanned (ST_SEL_START, ST_SEL), then ST_FLUSH.
// Reset clears all control state; store contents stay undefined until written.
// A stall on the output holds the scan only when a second result is ready.
module activity_selection #(
  parameter int unsigned JOB_SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // load channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [actsel_pkg::ID_W-1:0]   job_id_i,
  input  logic [actsel_pkg::TIME_W-1:0] start_at_i,
  input  logic [actsel_pkg::TIME_W-1:0] finish_at_i,
  input  logic                          final_job_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [actsel_pkg::ID_W-1:0]   chosen_id_o,
  output logic [actsel_pkg::CNT_W-1:0]  chosen_count_o,
  output logic                          overflowed_o,
  output logic                          run_end_o
);
  import actsel_pkg::*;

  localparam int unsigned IDX_W = $clog2(JOB_SLOTS);
  localparam int unsigned LD_W  = $clog2(JOB_SLOTS + 1);

  state_e state_q, state_d;

  // control state
  logic [LD_W-1:0]   loaded_q;
  logic              dropped_q;
  logic [TIME_W-1:0] last_finish_q;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  idx_q;
  logic              pend_vld_q;
  logic              out_valid_q;

  // payload state
  job_t              new_q;
  logic              final_q;
  logic [IDX_W-1:0]  pos_q;
  logic [ID_W-1:0]   pend_id_q;
  logic [CNT_W-1:0]  pend_cnt_q;
  logic [ID_W-1:0]   out_id_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_ovf_q;
  logic              out_end_q;

  // store port
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  job_t              rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  job_t              wr_data;

  logic              accept, has_room, out_free;
  logic              shift, take, block, last_idx, at_limit, sel_done;
  logic              push, push_end;
  logic [CNT_W-1:0]  cnt_inc;
  job_t              in_job;

  assign in_job     = '{id: job_id_i, start: start_at_i, finish: finish_at_i};
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign has_room   = (loaded_q != LD_W'(JOB_SLOTS));
  assign out_free   = !out_valid_q || !out_stall_i;

  // insertion: the stored neighbor moves up while its finish is later
  assign shift      = (rd_data.finish > new_q.finish);

  // selection: slot 0 is always taken, later ones when compatible
  assign take       = (idx_q == '0) || (rd_data.start >= last_finish_q);
  assign block      = take && pend_vld_q && !out_free;
  assign cnt_inc    = count_q + CNT_W'(1);
  assign at_limit   = take && (cnt_inc == CNT_W'(RESULT_LIMIT));
  assign last_idx   = ((LD_W'(idx_q) + LD_W'(1)) == loaded_q);
  assign sel_done   = at_limit || last_idx;

  actsel_store #(
    .DEPTH (JOB_SLOTS)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!has_room || (loaded_q == '0)) begin
            state_d = final_job_i ? ST_SEL_START : ST_IDLE;
          end else begin
            state_d = ST_INS;
          end
        end
      end
      ST_INS: begin
        if (shift) begin
          state_d = (pos_q == IDX_W'(1)) ? ST_PLACE : ST_INS;
        end else begin
          state_d = final_q ? ST_SEL_START : ST_IDLE;
        end
      end
      ST_PLACE:     state_d = final_q ? ST_SEL_START : ST_IDLE;
      ST_SEL_START: state_d = ST_SEL;
      ST_SEL: begin
        if (!block && sel_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // store access and result pushes
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = new_q;
    push     = 1'b0;
    push_end = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && has_room) begin
          if (loaded_q == '0) begin
            wr_en   = 1'b1;
            wr_data = in_job;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(loaded_q - LD_W'(1));
          end
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        if (shift) begin
          wr_data = rd_data;
          if (pos_q != IDX_W'(1)) begin
            rd_en   = 1'b1;
            rd_addr = pos_q - IDX_W'(2);
          end
        end
      end
      ST_PLACE: begin
        wr_en = 1'b1;
      end
      ST_SEL_START: begin
        rd_en = 1'b1;
      end
      ST_SEL: begin
        if (!block) begin
          push = take && pend_vld_q;
          if (!sel_done) begin
            rd_en   = 1'b1;
            rd_addr = idx_q + IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        push     = out_free;
        push_end = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      loaded_q      <= '0;
      dropped_q     <= 1'b0;
      last_finish_q <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      pend_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (has_room) begin
              loaded_q <= loaded_q + LD_W'(1);
            end else begin
              dropped_q <= 1'b1;
            end
          end
        end
        ST_SEL_START: begin
          idx_q      <= '0;
          count_q    <= '0;
          pend_vld_q <= 1'b0;
        end
        ST_SEL: begin
          if (!block) begin
            if (take) begin
              pend_vld_q    <= 1'b1;
              count_q       <= cnt_inc;
              last_finish_q <= rd_data.finish;
            end
            if (!sel_done) begin
              idx_q <= idx_q + IDX_W'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            loaded_q   <= '0;
            dropped_q  <= 1'b0;
            pend_vld_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_q   <= in_job;
      final_q <= final_job_i;
      pos_q   <= IDX_W'(loaded_q);
    end
    if ((state_q == ST_INS) && shift) begin
      pos_q <= pos_q - IDX_W'(1);
    end
    if ((state_q == ST_SEL) && !block && take) begin
      pend_id_q  <= rd_data.id;
      pend_cnt_q <= cnt_inc;
    end
    if (push) begin
      out_id_q  <= pend_id_q;
      out_cnt_q <= pend_cnt_q;
      out_ovf_q <= dropped_q;
      out_end_q <= push_end;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign chosen_id_o    = out_id_q;
  assign chosen_count_o = out_cnt_q;
  assign overflowed_o   = out_ovf_q;
  assign run_end_o      = out_end_q;

endmodule

// File: sv/actsel_checker.sv
// Port-level checker for activity selection, bound to the top level.
`include "activity_selection_defines.svh"

module actsel_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [actsel_pkg::ID_W-1:0]   job_id_i,
  input logic [actsel_pkg::TIME_W-1:0] start_at_i,
  input logic [actsel_pkg::TIME_W-1:0] finish_at_i,
  input logic                          final_job_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [actsel_pkg::ID_W-1:0]   chosen_id_o,
  input logic [actsel_pkg::CNT_W-1:0]  chosen_count_o,
  input logic                          overflowed_o,
  input logic                          run_end_o
);
  import actsel_pkg::*;

  `AS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(chosen_id_o) && $stable(chosen_count_o) && $stable(overflowed_o) && $stable(run_end_o), "result changed while stalled")

  `AS_ASSERT_NOW(a_count_range, out_valid_o, (chosen_count_o != '0) && (chosen_count_o <= CNT_W'(RESULT_LIMIT)), "chosen_count out of range")

  `AS_ASSERT_NOW(a_run_busy, out_valid_o && !run_end_o, in_stall_o, "load taken before run ended")

  `AS_ASSERT_NEXT(a_final_starts, in_valid_i && !in_stall_o && final_job_i, in_stall_o, "final job did not start selection")

endmodule

bind activity_selection actsel_checker u_actsel_checker (.*);
